// ----- rtl/lphs_pkg.sv -----
package lphs_pkg;

	localparam int unsigned TableDepth = 1024;
	localparam int unsigned SlotW = 10;
	localparam int unsigned KeyW = 31;
	localparam int unsigned SizeW = 11;
	localparam int unsigned CntW = 11;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_CHK,
		S_DEL_CLR,
		S_CL_RD,
		S_CL_CHK,
		S_RI_INIT,
		S_RI_DIV,
		S_RI_RD,
		S_RI_CHK,
		S_DONE
	} state_t;

	// memory access request from the sequencer
	typedef struct packed {
		logic             rd;
		logic             wr;
		logic [SlotW-1:0] addr;
		logic             wvalid;
		logic [KeyW-1:0]  wkey;
	} mem_req_t;

	typedef struct packed {
		logic            valid;
		logic [KeyW-1:0] key;
	} mem_rsp_t;

endpackage

// ----- rtl/lphs_mod.sv -----
// Sequential restoring remainder: key % m, one quotient bit per cycle.
module lphs_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lphs_pkg::KeyW-1:0]    dividend,
	input  logic [lphs_pkg::SizeW-1:0]   divisor,
	output logic                         done,
	output logic [lphs_pkg::SlotW-1:0]   rem
);
	localparam int unsigned CntW = $clog2(lphs_pkg::KeyW + 1);

	logic [lphs_pkg::KeyW-1:0]  num_q;
	logic [lphs_pkg::SizeW:0]   rem_q;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q;
	logic [lphs_pkg::SizeW:0]   shifted;
	logic [lphs_pkg::SizeW:0]   diff;

	assign shifted = {rem_q[lphs_pkg::SizeW-1:0], num_q[lphs_pkg::KeyW-1]};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(lphs_pkg::KeyW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[lphs_pkg::KeyW-2:0], 1'b0};
			rem_q <= diff[lphs_pkg::SizeW] ? shifted : diff;
		end
	end

	assign rem = rem_q[lphs_pkg::SlotW-1:0];
endmodule

// ----- rtl/lphs_mem.sv -----
// Slot memory: one word per slot holding the valid bit and the key.
// After reset a clearing pass empties slot 0 up to TableDepth-1, one a cycle.
module lphs_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  lphs_pkg::mem_req_t  req,
	output lphs_pkg::mem_rsp_t  rsp,
	output logic                clearing
);
	lphs_pkg::mem_rsp_t          mem_q [lphs_pkg::TableDepth];
	logic [lphs_pkg::SlotW-1:0]  clr_addr_q;
	logic                        clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == lphs_pkg::SlotW'(lphs_pkg::TableDepth - 1))
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem_q[clr_addr_q] <= '0;
		else if (req.wr)
			mem_q[req.addr] <= {req.wvalid, req.wkey};
		if (req.rd)
			rsp <= mem_q[req.addr];
	end

	assign clearing = clr_q;
endmodule

// ----- rtl/lphs_ctrl.sv -----
// Probe sequencer: insert, search, delete with cluster reinsertion.
module lphs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    mode,
	input  logic [lphs_pkg::KeyW-1:0]     key,
	input  logic [lphs_pkg::SizeW-1:0]    eff_m,
	input  logic                          res_take,
	output logic                          busy,
	output logic                          res_valid,
	output logic                          res_found,
	output logic [lphs_pkg::SlotW-1:0]    res_slot,
	output logic [1:0]                    res_status,
	output lphs_pkg::mem_req_t            mreq,
	input  lphs_pkg::mem_rsp_t            mrsp,
	output logic [lphs_pkg::CntW-1:0]     count
);
	lphs_pkg::state_t state_q, state_d;

	logic [1:0]                 mode_q;
	logic [lphs_pkg::KeyW-1:0]  key_q;
	logic [lphs_pkg::KeyW-1:0]  mv_key_q;
	logic [lphs_pkg::SlotW-1:0] h_q;
	logic [lphs_pkg::SizeW-1:0] n_q;
	logic [lphs_pkg::SlotW-1:0] pos_q;
	logic [lphs_pkg::SlotW-1:0] ch_q;
	logic [lphs_pkg::SizeW-1:0] cn_q;
	logic [lphs_pkg::CntW-1:0]  cnt_q;
	logic                       wk_found_q;
	logic [lphs_pkg::SlotW-1:0] wk_slot_q;
	logic [1:0]                 wk_status_q;
	logic                       res_valid_q;
	logic                       res_found_q;
	logic [lphs_pkg::SlotW-1:0] res_slot_q;
	logic [1:0]                 res_status_q;

	logic                       div_start;
	logic                       div_done;
	logic [lphs_pkg::SlotW-1:0] div_rem;
	logic [lphs_pkg::KeyW-1:0]  div_arg;
	logic [lphs_pkg::SlotW-1:0] h_nx;
	logic [lphs_pkg::SlotW-1:0] ch_nx;
	logic                       lap_end;
	logic                       hit;

	lphs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_arg),
		.divisor  (eff_m),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign div_arg   = (state_q == lphs_pkg::S_IDLE) ? key :
		(state_q == lphs_pkg::S_RI_INIT) ? mv_key_q : key_q;
	assign div_start = (state_q == lphs_pkg::S_IDLE && start) ||
		(state_q == lphs_pkg::S_RI_INIT);
	assign h_nx  = ({1'b0, h_q} + 1'b1 >= eff_m) ? '0 : h_q + 1'b1;
	assign ch_nx = ({1'b0, ch_q} + 1'b1 >= eff_m) ? '0 : ch_q + 1'b1;
	assign lap_end = (n_q + 1'b1 >= eff_m);
	assign hit     = mrsp.valid && mrsp.key == key_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lphs_pkg::S_IDLE:
				if (start)
					state_d = lphs_pkg::S_DIV;
			lphs_pkg::S_DIV:
				if (div_done)
					state_d = lphs_pkg::S_RD;
			lphs_pkg::S_RD:
				state_d = lphs_pkg::S_CHK;
			lphs_pkg::S_CHK: begin
				if (!mrsp.valid || hit || lap_end) begin
					if (mode_q == lphs_pkg::MODE_DELETE && hit)
						state_d = lphs_pkg::S_DEL_CLR;
					else
						state_d = lphs_pkg::S_DONE;
				end else
					state_d = lphs_pkg::S_RD;
			end
			lphs_pkg::S_DEL_CLR:
				state_d = (eff_m > 11'd1) ? lphs_pkg::S_CL_RD : lphs_pkg::S_DONE;
			lphs_pkg::S_CL_RD:
				state_d = lphs_pkg::S_CL_CHK;
			lphs_pkg::S_CL_CHK:
				state_d = mrsp.valid ? lphs_pkg::S_RI_INIT : lphs_pkg::S_DONE;
			lphs_pkg::S_RI_INIT:
				state_d = lphs_pkg::S_RI_DIV;
			lphs_pkg::S_RI_DIV:
				if (div_done)
					state_d = lphs_pkg::S_RI_RD;
			lphs_pkg::S_RI_RD:
				state_d = lphs_pkg::S_RI_CHK;
			lphs_pkg::S_RI_CHK:
				if (!mrsp.valid || mrsp.key == mv_key_q || lap_end) begin
					// cluster walk bounded by m-1 slots
					if (cn_q + 1'b1 + 1'b1 < eff_m)
						state_d = lphs_pkg::S_CL_RD;
					else
						state_d = lphs_pkg::S_DONE;
				end else
					state_d = lphs_pkg::S_RI_RD;
			lphs_pkg::S_DONE:
				if (!res_valid_q || res_take)
					state_d = lphs_pkg::S_IDLE;
			default:
				state_d = lphs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			lphs_pkg::S_RD, lphs_pkg::S_RI_RD: begin
				mreq.rd   = 1'b1;
				mreq.addr = h_q;
			end
			lphs_pkg::S_CHK:
				if (mode_q == lphs_pkg::MODE_INSERT && !mrsp.valid) begin
					mreq.wr     = 1'b1;
					mreq.addr   = h_q;
					mreq.wvalid = 1'b1;
					mreq.wkey   = key_q;
				end
			lphs_pkg::S_DEL_CLR: begin
				mreq.wr   = 1'b1;
				mreq.addr = pos_q;
			end
			lphs_pkg::S_CL_RD: begin
				mreq.rd   = 1'b1;
				mreq.addr = ch_q;
			end
			lphs_pkg::S_CL_CHK:
				if (mrsp.valid) begin
					mreq.wr   = 1'b1;
					mreq.addr = ch_q;
				end
			lphs_pkg::S_RI_CHK:
				if (!mrsp.valid) begin
					mreq.wr     = 1'b1;
					mreq.addr   = h_q;
					mreq.wvalid = 1'b1;
					mreq.wkey   = mv_key_q;
				end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphs_pkg::S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_take)
				res_valid_q <= 1'b0;
			if (state_q == lphs_pkg::S_DONE && state_d == lphs_pkg::S_IDLE)
				res_valid_q <= 1'b1;
			if (state_q == lphs_pkg::S_CHK && mode_q == lphs_pkg::MODE_INSERT &&
				!mrsp.valid)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == lphs_pkg::S_DEL_CLR)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lphs_pkg::S_IDLE:
				if (start) begin
					mode_q      <= mode;
					key_q       <= key;
					n_q         <= '0;
					wk_found_q  <= 1'b0;
					wk_slot_q   <= '0;
					wk_status_q <= lphs_pkg::ST_NOT_FOUND;
				end
			lphs_pkg::S_DIV:
				if (div_done)
					h_q <= div_rem;
			lphs_pkg::S_CHK: begin
				if (mode_q == lphs_pkg::MODE_NONE) begin
					wk_status_q <= lphs_pkg::ST_NOT_FOUND;
				end else if (!mrsp.valid) begin
					if (mode_q == lphs_pkg::MODE_INSERT) begin
						wk_found_q  <= 1'b1;
						wk_slot_q   <= h_q;
						wk_status_q <= lphs_pkg::ST_OK;
					end
				end else if (mrsp.key == key_q) begin
					wk_found_q  <= 1'b1;
					wk_slot_q   <= h_q;
					wk_status_q <= lphs_pkg::ST_OK;
					pos_q       <= h_q;
					ch_q        <= ({1'b0, h_q} + 1'b1 >= eff_m) ? '0 : h_q + 1'b1;
					cn_q        <= '0;
				end else if (lap_end) begin
					if (mode_q == lphs_pkg::MODE_INSERT)
						wk_status_q <= lphs_pkg::ST_FULL;
				end
				h_q <= h_nx;
				n_q <= n_q + 1'b1;
			end
			lphs_pkg::S_CL_CHK:
				mv_key_q <= mrsp.key;
			lphs_pkg::S_RI_DIV:
				if (div_done) begin
					h_q <= div_rem;
					n_q <= '0;
				end
			lphs_pkg::S_RI_CHK: begin
				h_q <= h_nx;
				n_q <= n_q + 1'b1;
				if (!mrsp.valid || mrsp.key == mv_key_q || lap_end) begin
					ch_q <= ch_nx;
					cn_q <= cn_q + 1'b1;
				end
			end
			// output register loads only when the previous result has left
			lphs_pkg::S_DONE:
				if (state_d == lphs_pkg::S_IDLE) begin
					res_found_q  <= wk_found_q;
					res_slot_q   <= wk_slot_q;
					res_status_q <= wk_status_q;
				end
			default: ;
		endcase
	end

	// mode 3 touches nothing: it still probes, but writes only on insert/delete
	assign busy       = (state_q != lphs_pkg::S_IDLE);
	assign res_valid  = res_valid_q;
	assign res_found  = res_found_q;
	assign res_slot   = res_slot_q;
	assign res_status = res_status_q;
	assign count      = cnt_q;
endmodule

// ----- rtl/linear_probe_hash_set.sv -----
// Flow: a request runs the serial remainder, then reads and checks its home
// slot and hands the result to the output register; each further probe adds
// another read and check. A delete that hits clears its slot, then per moved
// key reads it, recomputes its remainder and probes to reinsert it. One
// request in flight. Reset: a clearing pass empties every slot with input held
// off; occupancy to zero, table_size to 1024.
module linear_probe_hash_set (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // mode[1:0], key[32:2], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // found[0], slot[10:1], status[12:11], pad
);
	logic [lphs_pkg::SizeW-1:0] size_q;
	logic [lphs_pkg::SizeW-1:0] eff_m;
	logic                       busy;
	logic                       clearing;
	logic                       res_found;
	logic [lphs_pkg::SlotW-1:0] res_slot;
	logic [1:0]                 res_status;
	logic [lphs_pkg::CntW-1:0]  count;
	lphs_pkg::mem_req_t         mreq;
	lphs_pkg::mem_rsp_t         mrsp;
	logic                       start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= lphs_pkg::SizeW'(lphs_pkg::TableDepth);
		else if (cfg_we)
			size_q <= cfg_wdata;
	end

	assign eff_m = (size_q == '0) ? lphs_pkg::SizeW'(1) :
		(size_q > lphs_pkg::SizeW'(lphs_pkg::TableDepth)) ?
		lphs_pkg::SizeW'(lphs_pkg::TableDepth) : size_q;

	assign s_axis_tready = !busy && !clearing;
	assign start = s_axis_tvalid && s_axis_tready;

	lphs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (s_axis_tdata[1:0]),
		.key        (s_axis_tdata[32:2]),
		.eff_m      (eff_m),
		.res_take   (m_axis_tready),
		.busy       (busy),
		.res_valid  (m_axis_tvalid),
		.res_found  (res_found),
		.res_slot   (res_slot),
		.res_status (res_status),
		.mreq       (mreq),
		.mrsp       (mrsp),
		.count      (count)
	);

	lphs_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.rsp      (mrsp),
		.clearing (clearing)
	);

	assign m_axis_tdata = {3'b000, res_status, res_slot, res_found};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("accept while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= lphs_pkg::CntW'(lphs_pkg::TableDepth)) else $error("count overflow");
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.rd && mreq.wr)) else $error("read and write together");
endmodule

// ----- verif/tb.sv -----
module tb;
	typedef struct packed {
		lphs_pkg::status_t          status;
		logic [lphs_pkg::SlotW-1:0] slot;
		logic                       found;
	} lookup_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	linear_probe_hash_set u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// shadow of the table
	logic [lphs_pkg::KeyW-1:0] shadow_keys [lphs_pkg::TableDepth];
	bit                        shadow_valid [lphs_pkg::TableDepth];
	int unsigned               size_reg;

	lookup_t     pending_lookups[$];
	int          errors;
	int          idle_cycles;
	bit          rx_long_hold;
	int unsigned live_keys[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned active_size();
		int unsigned s;
		s = size_reg;
		if (s == 0) s = 1;
		if (s > lphs_pkg::TableDepth) s = lphs_pkg::TableDepth;
		return s;
	endfunction

	function automatic int unsigned step_slot(int unsigned h, int unsigned m);
		return (h + 1 >= m) ? 0 : h + 1;
	endfunction

	function automatic bit find_key(logic [lphs_pkg::KeyW-1:0] key, int unsigned m,
			output int unsigned pos);
		int unsigned h;
		h = key % m;
		pos = 0;
		for (int unsigned n = 0; n < m; n++) begin
			if (!shadow_valid[h]) return 0;
			if (shadow_keys[h] == key) begin
				pos = h;
				return 1;
			end
			h = step_slot(h, m);
		end
		return 0;
	endfunction

	// 0 stored, 1 present, 2 full
	function automatic int place_key(logic [lphs_pkg::KeyW-1:0] key, int unsigned m,
			output int unsigned pos);
		int unsigned h;
		h = key % m;
		pos = 0;
		for (int unsigned n = 0; n < m; n++) begin
			if (!shadow_valid[h]) begin
				shadow_valid[h] = 1;
				shadow_keys[h] = key;
				pos = h;
				return 0;
			end
			if (shadow_keys[h] == key) begin
				pos = h;
				return 1;
			end
			h = step_slot(h, m);
		end
		return 2;
	endfunction

	function automatic lookup_t predict_lookup(lphs_pkg::mode_t mode,
			logic [lphs_pkg::KeyW-1:0] key);
		lookup_t     r;
		int unsigned m, pos, h, tmp;
		int          rc;
		logic [lphs_pkg::KeyW-1:0] moved;
		m = active_size();
		r = '{found: 0, slot: '0, status: lphs_pkg::ST_NOT_FOUND};
		case (mode)
			lphs_pkg::MODE_INSERT: begin
				rc = place_key(key, m, pos);
				if (rc == 2) r.status = lphs_pkg::ST_FULL;
				else r = '{found: 1, slot: pos[lphs_pkg::SlotW-1:0],
					status: lphs_pkg::ST_OK};
			end
			lphs_pkg::MODE_SEARCH: begin
				if (find_key(key, m, pos))
					r = '{found: 1, slot: pos[lphs_pkg::SlotW-1:0],
						status: lphs_pkg::ST_OK};
			end
			lphs_pkg::MODE_DELETE: begin
				if (find_key(key, m, pos)) begin
					shadow_valid[pos] = 0;
					h = step_slot(pos, m);
					for (int unsigned n = 0; n + 1 < m && shadow_valid[h]; n++) begin
						moved = shadow_keys[h];
						shadow_valid[h] = 0;
						void'(place_key(moved, m, tmp));
						h = step_slot(h, m);
					end
					r = '{found: 1, slot: pos[lphs_pkg::SlotW-1:0],
						status: lphs_pkg::ST_OK};
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(lphs_pkg::mode_t mode, logic [lphs_pkg::KeyW-1:0] key);
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
				: $urandom_range(1, 3);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'd0, key, mode};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_lookups.push_back(predict_lookup(mode, key));
		if (mode == lphs_pkg::MODE_INSERT) live_keys.push_back(32'(key));
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_size(int unsigned value);
		drain();
		cfg_we <= 1;
		cfg_wdata <= value[10:0];
		@(posedge clk);
		cfg_we <= 0;
		size_reg = 32'(value[10:0]);
	endtask

	function automatic logic [lphs_pkg::KeyW-1:0] pick_key(int unsigned m);
		if (live_keys.size() != 0 && $urandom_range(0, 1))
			return lphs_pkg::KeyW'(live_keys[$urandom_range(0, live_keys.size() - 1)]);
		case ($urandom_range(0, 3))
			0: return lphs_pkg::KeyW'($urandom_range(0, 3 * m));
			1: return lphs_pkg::KeyW'($urandom);
			default: return lphs_pkg::KeyW'($urandom_range(0, 7) * m +
				$urandom_range(0, 2));
		endcase
	endfunction

	task automatic random_ops(int count, int weight_insert);
		int unsigned r, m;
		lphs_pkg::mode_t mode;
		m = active_size();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < weight_insert) mode = lphs_pkg::MODE_INSERT;
			else if (r < weight_insert + 25) mode = lphs_pkg::MODE_SEARCH;
			else if (r < 97) mode = lphs_pkg::MODE_DELETE;
			else mode = lphs_pkg::MODE_NONE;
			send_request(mode, pick_key(m));
		end
	endtask

	task automatic test_directed();
		send_request(lphs_pkg::MODE_SEARCH, 31'h7FFFFFFF);
		send_request(lphs_pkg::MODE_INSERT, 31'h7FFFFFFF);
		send_request(lphs_pkg::MODE_INSERT, 31'h7FFFFFFF);
		send_request(lphs_pkg::MODE_INSERT, 31'd0);
		send_request(lphs_pkg::MODE_INSERT, 31'd1024);
		send_request(lphs_pkg::MODE_INSERT, 31'h2AAAAAAA);
		send_request(lphs_pkg::MODE_INSERT, 31'h55555555);
		send_request(lphs_pkg::MODE_SEARCH, 31'd1024);
		send_request(lphs_pkg::MODE_DELETE, 31'd0);
		send_request(lphs_pkg::MODE_SEARCH, 31'd1024);
		send_request(lphs_pkg::MODE_DELETE, 31'd5);
		send_request(lphs_pkg::MODE_NONE, 31'd1024);
		send_request(lphs_pkg::MODE_NONE, 31'h7FFFFFFF);
		send_request(lphs_pkg::MODE_INSERT, 31'd1023);
		send_request(lphs_pkg::MODE_INSERT, 31'd2047);
		send_request(lphs_pkg::MODE_DELETE, 31'd1023);
		send_request(lphs_pkg::MODE_SEARCH, 31'd2047);
	endtask

	// small table: fill it, hit full, wraparound clusters
	task automatic test_full_table();
		write_size(4);
		for (int k = 0; k < 6; k++) send_request(lphs_pkg::MODE_INSERT, 31'(k * 4 + 3));
		send_request(lphs_pkg::MODE_SEARCH, 31'd99);
		send_request(lphs_pkg::MODE_DELETE, 31'd7);
		send_request(lphs_pkg::MODE_SEARCH, 31'd11);
		random_ops(60, 40);
	endtask

	task automatic test_size_extremes();
		write_size(0);
		random_ops(25, 50);
		write_size(1);
		random_ops(25, 50);
		write_size(2047);
		random_ops(60, 45);
		write_size(1024);
		random_ops(60, 45);
	endtask

	// sizes shrink and grow while keys remain stored
	task automatic test_size_changes();
		for (int p = 0; p < 8; p++) begin
			write_size($urandom_range(2, 40));
			random_ops(80, 45);
		end
	endtask

	task automatic test_backpressure();
		rx_long_hold = 1;
		random_ops(12, 60);
		rx_long_hold = 0;
		drain();
		random_ops(100, 45);
	endtask

	// receiver stalls
	initial begin
		m_axis_tready = 1;
		forever begin
			@(posedge clk);
			if (rx_long_hold) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				m_axis_tready <= 1;
				wait (!rx_long_hold);
			end else if ($urandom_range(0, 4) == 0) begin
				m_axis_tready <= 0;
				repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3)) @(posedge clk);
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		lookup_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[12:0];
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_lookups.pop_front();
				if (got.found !== want.found)
					$display("%0t: found exp %0d got %0d", $time, want.found, got.found);
				if (got.slot !== want.slot)
					$display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got !== want) errors++;
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		rx_long_hold = 0;
		size_reg = 1024;
		for (int i = 0; i < lphs_pkg::TableDepth; i++) shadow_valid[i] = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_full_table();
		test_size_extremes();
		test_size_changes();
		drain();
		if (errors == 0 && pending_lookups.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
